>>> rtl/core/vrt_pkg.sv
// ---------------------------------------------------------------------------
// vrt_pkg: shared types and constants of the voxel ray traversal core
// Default parameters, datapath op codes and the controller/datapath structs.
// ---------------------------------------------------------------------------
package vrt_pkg;

	localparam int GRID_SIZE_DEF = 32;
	localparam int FRAC_BITS_DEF = 16;
	localparam int MAX_REACH_DEF = 16;

	typedef logic [3:0] vrt_op_t;

	localparam vrt_op_t OP_NONE       = 4'd0;
	localparam vrt_op_t OP_CLR        = 4'd1;
	localparam vrt_op_t OP_LOAD       = 4'd2;
	localparam vrt_op_t OP_WRITE      = 4'd3;
	localparam vrt_op_t OP_SQ         = 4'd4;
	localparam vrt_op_t OP_SQRT_INIT  = 4'd5;
	localparam vrt_op_t OP_SQRT_STEP  = 4'd6;
	localparam vrt_op_t OP_STORE_INF  = 4'd7;
	localparam vrt_op_t OP_DIV_INIT   = 4'd8;
	localparam vrt_op_t OP_DIV_STEP   = 4'd9;
	localparam vrt_op_t OP_DIV_STORE  = 4'd10;
	localparam vrt_op_t OP_MUL_FD     = 4'd11;
	localparam vrt_op_t OP_READ       = 4'd12;
	localparam vrt_op_t OP_HIT        = 4'd13;
	localparam vrt_op_t OP_STEP       = 4'd14;
	localparam vrt_op_t OP_OUT_LOAD   = 4'd15;

	// sel_max: 0 = tDelta division, 1 = tMax division
	typedef struct packed {
		vrt_op_t     op;
		logic [1:0]  axis;
		logic        sel_max;
	} vrt_cmd_t;

	typedef struct packed {
		logic is_write;
		logic dir_zero;
		logic axis_zero;
		logic solid;
		logic over_lim;
		logic clr_done;
	} vrt_sts_t;

endpackage

>>> rtl/core/vrt_ram.sv
// ---------------------------------------------------------------------------
// vrt_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module vrt_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 32768
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/core/vrt_ctrl.sv
// ---------------------------------------------------------------------------
// vrt_ctrl: sequencer of the voxel ray traversal core
// Clearing pass, request decode, setup sequencing, DDA walk and output hold.
// ---------------------------------------------------------------------------
module vrt_ctrl import vrt_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	output vrt_cmd_t cmd,
	input  vrt_sts_t sts
);

	localparam int DIV_STEPS  = FRAC_BITS + 25;
	localparam int SQRT_STEPS = 24;
	localparam int CNT_W      = $clog2(DIV_STEPS);

	localparam logic [3:0] ST_CLEAR  = 4'd0;
	localparam logic [3:0] ST_IDLE   = 4'd1;
	localparam logic [3:0] ST_DECODE = 4'd2;
	localparam logic [3:0] ST_WRITE  = 4'd3;
	localparam logic [3:0] ST_SQ     = 4'd4;
	localparam logic [3:0] ST_SQRT_I = 4'd5;
	localparam logic [3:0] ST_SQRT   = 4'd6;
	localparam logic [3:0] ST_AXIS   = 4'd7;
	localparam logic [3:0] ST_MUL    = 4'd8;
	localparam logic [3:0] ST_DIV_I  = 4'd9;
	localparam logic [3:0] ST_DIV    = 4'd10;
	localparam logic [3:0] ST_STORE  = 4'd11;
	localparam logic [3:0] ST_RD     = 4'd12;
	localparam logic [3:0] ST_CHK    = 4'd13;
	localparam logic [3:0] ST_STEP   = 4'd14;
	localparam logic [3:0] ST_OUT    = 4'd15;

	logic [3:0]       state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic [1:0]       axis_q, axis_d;
	logic             sel_q, sel_d;
	logic             out_valid_q;
	logic             out_load;

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		axis_d   = axis_q;
		sel_d    = sel_q;
		cmd.op      = OP_NONE;
		cmd.axis    = axis_q;
		cmd.sel_max = sel_q;
		in_ready = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.op = OP_CLR;
				if (sts.clr_done) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op  = OP_LOAD;
					state_d = ST_DECODE;
				end
			end
			ST_DECODE: begin
				cnt_d = '0;
				if (sts.is_write)      state_d = ST_WRITE;
				else if (sts.dir_zero) state_d = ST_OUT;
				else                   state_d = ST_SQ;
			end
			ST_WRITE: begin
				cmd.op  = OP_WRITE;
				state_d = ST_OUT;
			end
			ST_SQ: begin
				cmd.op   = OP_SQ;
				cmd.axis = cnt_q[1:0];
				if (cnt_q == CNT_W'(3)) state_d = ST_SQRT_I;
				else cnt_d = cnt_q + 1'b1;
			end
			ST_SQRT_I: begin
				cmd.op  = OP_SQRT_INIT;
				cnt_d   = '0;
				state_d = ST_SQRT;
			end
			ST_SQRT: begin
				cmd.op = OP_SQRT_STEP;
				if (cnt_q == CNT_W'(SQRT_STEPS - 1)) begin
					axis_d  = 2'd0;
					state_d = ST_AXIS;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			ST_AXIS: begin
				sel_d = 1'b0;
				if (sts.axis_zero) begin
					cmd.op = OP_STORE_INF;
					if (axis_q == 2'd2) state_d = ST_RD;
					else axis_d = axis_q + 1'b1;
				end else begin
					state_d = ST_DIV_I;
				end
			end
			ST_MUL: begin
				cmd.op  = OP_MUL_FD;
				state_d = ST_DIV_I;
			end
			ST_DIV_I: begin
				cmd.op  = OP_DIV_INIT;
				cnt_d   = '0;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				cmd.op = OP_DIV_STEP;
				if (cnt_q == CNT_W'(DIV_STEPS - 1)) state_d = ST_STORE;
				else cnt_d = cnt_q + 1'b1;
			end
			ST_STORE: begin
				cmd.op = OP_DIV_STORE;
				if (!sel_q) begin
					sel_d   = 1'b1;
					state_d = ST_MUL;
				end else if (axis_q == 2'd2) begin
					state_d = ST_RD;
				end else begin
					axis_d  = axis_q + 1'b1;
					state_d = ST_AXIS;
				end
			end
			ST_RD: begin
				cmd.op  = OP_READ;
				state_d = ST_CHK;
			end
			ST_CHK: begin
				if (sts.solid) begin
					cmd.op  = OP_HIT;
					state_d = ST_OUT;
				end else begin
					state_d = ST_STEP;
				end
			end
			ST_STEP: begin
				if (sts.over_lim) begin
					state_d = ST_OUT;
				end else begin
					cmd.op  = OP_STEP;
					state_d = ST_RD;
				end
			end
			ST_OUT: begin
				if (!out_valid_q || out_ready) begin
					cmd.op   = OP_OUT_LOAD;
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			cnt_q       <= '0;
			axis_q      <= '0;
			sel_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			axis_q  <= axis_d;
			sel_q   <= sel_d;
			if (out_load)       out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

>>> rtl/core/vrt_dpath.sv
// ---------------------------------------------------------------------------
// vrt_dpath: datapath of the voxel ray traversal core
// Occupancy RAM, multipliers, bit-serial root and divider, DDA state.
// ---------------------------------------------------------------------------
module vrt_dpath import vrt_pkg::*; #(
	parameter int GRID_SIZE = GRID_SIZE_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF,
	parameter int MAX_REACH = MAX_REACH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_type,
	input  logic [4:0]         voxel_x,
	input  logic [4:0]         voxel_y,
	input  logic [4:0]         voxel_z,
	input  logic               solid_bit,
	input  logic signed [23:0] start_x,
	input  logic signed [23:0] start_y,
	input  logic signed [23:0] start_z,
	input  logic signed [15:0] dir_x,
	input  logic signed [15:0] dir_y,
	input  logic signed [15:0] dir_z,
	input  logic [23:0]        reach,
	input  vrt_cmd_t           cmd,
	output vrt_sts_t           sts,
	output logic               hit,
	output logic signed [7:0]  target_x,
	output logic signed [7:0]  target_y,
	output logic signed [7:0]  target_z,
	output logic signed [1:0]  normal_x,
	output logic signed [1:0]  normal_y,
	output logic signed [1:0]  normal_z,
	output logic signed [7:0]  place_x,
	output logic signed [7:0]  place_y,
	output logic signed [7:0]  place_z,
	output logic [23:0]        distance
);

	localparam int CELLS  = GRID_SIZE * GRID_SIZE * GRID_SIZE;
	localparam int ADDR_W = $clog2(CELLS);
	localparam int IDX_W  = $clog2(GRID_SIZE);
	localparam int CELL_W = 24 - FRAC_BITS + 9;
	localparam int P_W    = FRAC_BITS + 25;
	localparam int T_W    = FRAC_BITS + 27;
	localparam int LIM_W  = FRAC_BITS + 15;
	localparam logic [T_W-1:0]       T_INF = T_W'(1) << (T_W - 1);
	localparam logic [31:0]          R_SAT = 32'(MAX_REACH) << FRAC_BITS;
	localparam logic [FRAC_BITS:0]   ONE   = (FRAC_BITS + 1)'(1) << FRAC_BITS;

	// captured request
	logic                     req_q, wsolid_q;
	logic [4:0]               vox_q [3];
	logic signed [15:0]       d_q [3];
	logic [FRAC_BITS-1:0]     frac_q [3];
	logic signed [CELL_W-1:0] cell_q [3];
	logic [LIM_W-1:0]         lim_q;

	// setup arithmetic
	logic [31:0]      acc_q;
	logic [P_W-1:0]   p_q;
	logic [47:0]      sq_v_q, sq_r_q, sq_b_q;
	logic [P_W-1:0]   quo_q;
	logic [15:0]      rem_q, dvs_q;

	// DDA state
	logic [T_W-1:0]     tm_q [3];
	logic [T_W-1:0]     td_q [3];
	logic [T_W-1:0]     t_q;
	logic signed [1:0]  nrm_q [3];

	// result and output registers
	logic               res_hit_q, out_hit_q;
	logic signed [7:0]  res_tgt_q [3];
	logic signed [1:0]  res_nrm_q [3];
	logic [23:0]        res_dist_q, out_dist_q;
	logic signed [7:0]  out_tgt_q [3];
	logic signed [1:0]  out_nrm_q [3];
	logic signed [7:0]  out_plc_q [3];

	logic [ADDR_W-1:0] clr_addr_q;

	logic [15:0]      ad [3];
	logic [15:0]      ad_sel;
	logic [FRAC_BITS:0] fd_sel;
	logic [23:0]      len;
	logic [47:0]      sq_rb;
	logic [16:0]      rem2;
	logic             div_ge;
	logic [1:0]       ax;
	logic [T_W-1:0]   t_sel;
	logic [2:0]       in_grid;
	logic             wr_in_grid;
	logic             ram_we, ram_rd;
	logic [ADDR_W-1:0] ram_waddr, ram_raddr, cell_addr, vox_addr;

	function automatic logic [15:0] abs16(input logic signed [15:0] v);
		return v[15] ? (~v + 16'd1) : v;
	endfunction

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			ad[i]      = abs16(d_q[i]);
			in_grid[i] = !cell_q[i][CELL_W-1] && (32'(cell_q[i]) < 32'(GRID_SIZE));
		end
		unique case (cmd.axis)
			2'd0:    ad_sel = ad[0];
			2'd1:    ad_sel = ad[1];
			2'd2:    ad_sel = ad[2];
			default: ad_sel = '0;
		endcase
		if (cmd.axis == 2'd3)        fd_sel = '0;
		else if (d_q[cmd.axis][15])  fd_sel = (FRAC_BITS + 1)'(frac_q[cmd.axis]);
		else                         fd_sel = ONE - (FRAC_BITS + 1)'(frac_q[cmd.axis]);
	end

	assign len    = sq_r_q[23:0];
	assign sq_rb  = sq_r_q + sq_b_q;
	assign rem2   = {rem_q, quo_q[P_W-1]};
	assign div_ge = rem2 >= {1'b0, dvs_q};

	// strict compares: ties fall to the later axis (X loses to Y or Z, Y to Z)
	always_comb begin
		if (tm_q[0] < tm_q[1]) ax = (tm_q[0] < tm_q[2]) ? 2'd0 : 2'd2;
		else                   ax = (tm_q[1] < tm_q[2]) ? 2'd1 : 2'd2;
		t_sel = tm_q[ax];
	end

	assign wr_in_grid = (32'(vox_q[0]) < 32'(GRID_SIZE)) && (32'(vox_q[1]) < 32'(GRID_SIZE))
		&& (32'(vox_q[2]) < 32'(GRID_SIZE));
	assign vox_addr  = ADDR_W'(32'(vox_q[0]) * 32'(GRID_SIZE * GRID_SIZE)
		+ 32'(vox_q[1]) * 32'(GRID_SIZE) + 32'(vox_q[2]));
	assign cell_addr = ADDR_W'(32'(cell_q[0][IDX_W-1:0]) * 32'(GRID_SIZE * GRID_SIZE)
		+ 32'(cell_q[1][IDX_W-1:0]) * 32'(GRID_SIZE) + 32'(cell_q[2][IDX_W-1:0]));

	assign ram_we    = (cmd.op == OP_CLR) || ((cmd.op == OP_WRITE) && wr_in_grid);
	assign ram_waddr = (cmd.op == OP_CLR) ? clr_addr_q : vox_addr;
	assign ram_rd    = &in_grid;
	assign ram_raddr = ram_rd ? cell_addr : '0;

	logic ram_rdata;

	vrt_ram #(
		.WIDTH (1),
		.DEPTH (CELLS)
	) u_occ (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata ((cmd.op == OP_CLR) ? 1'b0 : wsolid_q),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_comb begin
		sts.is_write  = !req_q;
		sts.dir_zero  = (d_q[0] == 16'sd0) && (d_q[1] == 16'sd0) && (d_q[2] == 16'sd0);
		sts.axis_zero = (ad_sel == 16'd0);
		sts.solid     = ram_rdata && ram_rd;
		sts.over_lim  = t_sel > T_W'(lim_q);
		sts.clr_done  = (clr_addr_q == ADDR_W'(CELLS - 1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
		end else if (cmd.op == OP_CLR) begin
			clr_addr_q <= clr_addr_q + 1'b1;
		end
	end

	logic [31:0] reach_sat;
	assign reach_sat = ({8'd0, reach} > R_SAT) ? R_SAT : {8'd0, reach};

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_LOAD: begin
				req_q    <= req_type;
				wsolid_q <= solid_bit;
				vox_q[0] <= voxel_x;
				vox_q[1] <= voxel_y;
				vox_q[2] <= voxel_z;
				d_q[0]   <= dir_x;
				d_q[1]   <= dir_y;
				d_q[2]   <= dir_z;
				frac_q[0] <= start_x[FRAC_BITS-1:0];
				frac_q[1] <= start_y[FRAC_BITS-1:0];
				frac_q[2] <= start_z[FRAC_BITS-1:0];
				cell_q[0] <= CELL_W'(start_x >>> FRAC_BITS);
				cell_q[1] <= CELL_W'(start_y >>> FRAC_BITS);
				cell_q[2] <= CELL_W'(start_z >>> FRAC_BITS);
				lim_q     <= LIM_W'({reach_sat, 8'd0});
				acc_q     <= '0;
				p_q       <= '0;
				t_q       <= '0;
				nrm_q[0]  <= 2'sd0;
				nrm_q[1]  <= 2'sd1;
				nrm_q[2]  <= 2'sd0;
				res_hit_q  <= 1'b0;
				res_dist_q <= '0;
				for (int i = 0; i < 3; i++) begin
					res_tgt_q[i] <= '0;
					res_nrm_q[i] <= '0;
				end
			end
			OP_SQ: begin
				p_q   <= P_W'(ad_sel * ad_sel);
				acc_q <= acc_q + p_q[31:0];
			end
			OP_SQRT_INIT: begin
				sq_v_q <= {acc_q, 16'd0};
				sq_r_q <= '0;
				sq_b_q <= 48'd1 << 46;
			end
			OP_SQRT_STEP: begin
				if (sq_v_q >= sq_rb) begin
					sq_v_q <= sq_v_q - sq_rb;
					sq_r_q <= (sq_r_q >> 1) + sq_b_q;
				end else begin
					sq_r_q <= sq_r_q >> 1;
				end
				sq_b_q <= sq_b_q >> 2;
			end
			OP_STORE_INF: begin
				tm_q[cmd.axis] <= T_INF;
				td_q[cmd.axis] <= '0;
			end
			OP_MUL_FD: begin
				p_q <= fd_sel * len;
			end
			OP_DIV_INIT: begin
				dvs_q <= ad_sel;
				rem_q <= '0;
				quo_q <= cmd.sel_max ? p_q : P_W'({len, {FRAC_BITS{1'b0}}});
			end
			OP_DIV_STEP: begin
				rem_q <= div_ge ? 16'(rem2 - {1'b0, dvs_q}) : rem2[15:0];
				quo_q <= {quo_q[P_W-2:0], div_ge};
			end
			OP_DIV_STORE: begin
				if (cmd.sel_max) tm_q[cmd.axis] <= T_W'(quo_q);
				else             td_q[cmd.axis] <= T_W'(quo_q);
			end
			OP_STEP: begin
				t_q      <= t_sel;
				tm_q[ax] <= t_sel + td_q[ax];
				cell_q[ax] <= cell_q[ax] + (d_q[ax][15] ? {CELL_W{1'b1}} : CELL_W'(1));
				for (int i = 0; i < 3; i++) begin
					if (2'(i) == ax) nrm_q[i] <= d_q[ax][15] ? 2'sd1 : -2'sd1;
					else             nrm_q[i] <= 2'sd0;
				end
			end
			OP_HIT: begin
				res_hit_q  <= 1'b1;
				res_dist_q <= t_q[8 +: 24];
				for (int i = 0; i < 3; i++) begin
					res_tgt_q[i] <= cell_q[i][7:0];
					res_nrm_q[i] <= nrm_q[i];
				end
			end
			OP_OUT_LOAD: begin
				out_hit_q  <= res_hit_q;
				out_dist_q <= res_dist_q;
				for (int i = 0; i < 3; i++) begin
					out_tgt_q[i] <= res_tgt_q[i];
					out_nrm_q[i] <= res_nrm_q[i];
					out_plc_q[i] <= res_tgt_q[i] + {{6{res_nrm_q[i][1]}}, res_nrm_q[i]};
				end
			end
			default: ;
		endcase
	end

	assign hit      = out_hit_q;
	assign target_x = out_tgt_q[0];
	assign target_y = out_tgt_q[1];
	assign target_z = out_tgt_q[2];
	assign normal_x = out_nrm_q[0];
	assign normal_y = out_nrm_q[1];
	assign normal_z = out_nrm_q[2];
	assign place_x  = out_plc_q[0];
	assign place_y  = out_plc_q[1];
	assign place_z  = out_plc_q[2];
	assign distance = out_dist_q;

endmodule

>>> rtl/core/voxel_ray_traversal_core.sv
// ---------------------------------------------------------------------------
// voxel_ray_traversal_core: voxel grid with 3D DDA ray casting
// Holds a GRID_SIZE^3 occupancy grid; writes set one voxel, casts return
// the first solid voxel, entry face normal, placement cell and distance.
// ---------------------------------------------------------------------------
//
//  channel | handshake            | payload
//  --------+----------------------+------------------------------------------
//  in      | in_valid / in_ready  | req_type, voxel_*, solid_bit, start_*,
//          |                      | dir_*, reach
//  out     | out_valid / out_ready| hit, target_*, normal_*, place_*, distance
//
// Reset runs a clearing pass over the occupancy RAM, one voxel per cycle,
// with in_ready low.
// A write passes through decode, the RAM write and the output load; a
// zero-direction cast goes from decode straight to the output load. A cast
// with a nonzero direction squares the direction components and takes a
// bit-serial root, runs two serial divisions per nonzero direction axis and
// stores an infinite tMax per zero axis, then reads the start voxel, walks
// step, read and check per voxel (waiting on the registered occupancy RAM read), and loads the output register.
// One item is in flight at a time; the next is accepted as soon as the
// result is in the output register, which holds it through out_ready stalls.
//
module voxel_ray_traversal_core import vrt_pkg::*; #(
	parameter int GRID_SIZE = GRID_SIZE_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF,
	parameter int MAX_REACH = MAX_REACH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               req_type,
	input  logic [4:0]         voxel_x,
	input  logic [4:0]         voxel_y,
	input  logic [4:0]         voxel_z,
	input  logic               solid_bit,
	input  logic signed [23:0] start_x,
	input  logic signed [23:0] start_y,
	input  logic signed [23:0] start_z,
	input  logic signed [15:0] dir_x,
	input  logic signed [15:0] dir_y,
	input  logic signed [15:0] dir_z,
	input  logic [23:0]        reach,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               hit,
	output logic signed [7:0]  target_x,
	output logic signed [7:0]  target_y,
	output logic signed [7:0]  target_z,
	output logic signed [1:0]  normal_x,
	output logic signed [1:0]  normal_y,
	output logic signed [1:0]  normal_z,
	output logic signed [7:0]  place_x,
	output logic signed [7:0]  place_y,
	output logic signed [7:0]  place_z,
	output logic [23:0]        distance
);

	// controller -> datapath commands, datapath -> controller flags
	vrt_cmd_t cmd;
	vrt_sts_t sts;

	vrt_ctrl #(
		.FRAC_BITS (FRAC_BITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	// request capture, setup arithmetic, DDA walk and output register
	vrt_dpath #(
		.GRID_SIZE (GRID_SIZE),
		.FRAC_BITS (FRAC_BITS),
		.MAX_REACH (MAX_REACH)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_type  (req_type),
		.voxel_x   (voxel_x),
		.voxel_y   (voxel_y),
		.voxel_z   (voxel_z),
		.solid_bit (solid_bit),
		.start_x   (start_x),
		.start_y   (start_y),
		.start_z   (start_z),
		.dir_x     (dir_x),
		.dir_y     (dir_y),
		.dir_z     (dir_z),
		.reach     (reach),
		.cmd       (cmd),
		.sts       (sts),
		.hit       (hit),
		.target_x  (target_x),
		.target_y  (target_y),
		.target_z  (target_z),
		.normal_x  (normal_x),
		.normal_y  (normal_y),
		.normal_z  (normal_z),
		.place_x   (place_x),
		.place_y   (place_y),
		.place_z   (place_z),
		.distance  (distance)
	);

endmodule

>>> rtl/core/vrt_checker.sv
// ---------------------------------------------------------------------------
// vrt_checker: port-level checks of the voxel ray traversal core
// Result consistency and output hold, bound to the top level.
// ---------------------------------------------------------------------------
module vrt_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              out_valid,
	input logic              out_ready,
	input logic              hit,
	input logic signed [7:0] target_x,
	input logic signed [7:0] target_y,
	input logic signed [7:0] target_z,
	input logic signed [1:0] normal_x,
	input logic signed [1:0] normal_y,
	input logic signed [1:0] normal_z,
	input logic signed [7:0] place_x,
	input logic signed [7:0] place_y,
	input logic signed [7:0] place_z,
	input logic [23:0]       distance
);

	// a miss or write result carries all-zero fields
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !hit |-> target_x == 8'sd0 && target_y == 8'sd0 && target_z == 8'sd0
			&& normal_x == 2'sd0 && normal_y == 2'sd0 && normal_z == 2'sd0
			&& place_x == 8'sd0 && place_y == 8'sd0 && place_z == 8'sd0
			&& distance == 24'd0)
		else $error("miss result with nonzero fields");

	// a hit enters through exactly one face
	a_one_face: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && hit |-> $countones({normal_x != 2'sd0, normal_y != 2'sd0,
			normal_z != 2'sd0}) == 1 && normal_x != 2'sb10 && normal_y != 2'sb10
			&& normal_z != 2'sb10)
		else $error("hit normal is not a unit axis vector");

	// placement cell sits in front of the entered face
	a_place: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && hit |-> place_x == 8'(target_x + {{6{normal_x[1]}}, normal_x})
			&& place_y == 8'(target_y + {{6{normal_y[1]}}, normal_y})
			&& place_z == 8'(target_z + {{6{normal_z[1]}}, normal_z}))
		else $error("placement cell mismatch");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(hit) && $stable(distance)
			&& $stable(target_x) && $stable(place_z))
		else $error("stalled result changed");

endmodule

bind voxel_ray_traversal_core vrt_checker u_vrt_checker (.*);

>>> tb/tb.sv
// ---------------------------------------------------------------------------
// tb: self-checking testbench for voxel_ray_traversal_core
// Drives voxel writes and ray casts over valid/ready with random gaps and
// stalls. A built-in DDA predictor tracks the occupancy grid and checks every
// result field in order of arrival.
// ---------------------------------------------------------------------------
module tb;
	import vrt_pkg::*;

	localparam int GRID = GRID_SIZE_DEF;
	localparam int FRAC = FRAC_BITS_DEF;
	localparam int REACH_CAP = MAX_REACH_DEF;
	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_CAST = 1'b1;
	localparam int N_ROWS = 19;
	localparam int N_RANDOM = 430;
	localparam int WATCHDOG = 100000;	// covers the clearing pass after reset
	localparam int HOLD_CYCLES = 3000;
	localparam longint unsigned T_FAR = 64'h4000000000000000;

	typedef struct packed {
		logic              kind;
		logic [4:0]        vx, vy, vz;
		logic              sb;
		logic signed [23:0] sx, sy, sz;
		logic signed [15:0] dx, dy, dz;
		logic [23:0]       rch;
	} req_t;

	typedef struct packed {
		logic              hit;
		logic signed [7:0] tx, ty, tz;
		logic signed [1:0] nx, ny, nz;
		logic signed [7:0] px, py, pz;
		logic [23:0]       dst;
	} hit_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic out_valid;
	logic out_ready = 1'b0;
	req_t drv = '0;
	hit_t got;

	bit occ [GRID*GRID*GRID];
	hit_t pending_hits [$];
	req_t rows [N_ROWS];
	bit typed_row [N_ROWS];
	hit_t typed_hit [N_ROWS];

	int snd_idle = 0, rcv_idle = 0;
	bit hold_off = 1'b0, hold_go = 1'b0;
	int errors = 0, n_casts = 0, n_hits = 0, n_writes = 0, stall_cycles = 0;
	int quiet = 0;

	always #5 clk = ~clk;

	voxel_ray_traversal_core dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.req_type(drv.kind), .voxel_x(drv.vx), .voxel_y(drv.vy), .voxel_z(drv.vz),
		.solid_bit(drv.sb),
		.start_x(drv.sx), .start_y(drv.sy), .start_z(drv.sz),
		.dir_x(drv.dx), .dir_y(drv.dy), .dir_z(drv.dz), .reach(drv.rch),
		.out_valid(out_valid), .out_ready(out_ready),
		.hit(got.hit), .target_x(got.tx), .target_y(got.ty), .target_z(got.tz),
		.normal_x(got.nx), .normal_y(got.ny), .normal_z(got.nz),
		.place_x(got.px), .place_y(got.py), .place_z(got.pz), .distance(got.dst)
	);

	// ---- predictor ------------------------------------------------------

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned r = 0;
		longint unsigned b = 64'h4000000000000000;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic bit solid_at(longint x, longint y, longint z);
		if (x < 0 || x >= GRID || y < 0 || y >= GRID || z < 0 || z >= GRID)
			return 1'b0;
		return occ[(x * GRID + y) * GRID + z];
	endfunction

	// per-axis stepping setup: step sign, first boundary and boundary spacing
	function automatic void axis_init(input longint d, input longint unsigned frac,
			input longint unsigned len, output longint stp,
			output longint unsigned tnext, output longint unsigned tgap);
		longint unsigned ad, fd;
		if (d == 0) begin
			stp = 0;
			tnext = T_FAR;
			tgap = 0;
		end else begin
			ad = (d < 0) ? -d : d;
			stp = (d > 0) ? 1 : -1;
			fd = (d > 0) ? (64'd1 << FRAC) - frac : frac;
			tgap = (len << FRAC) / ad;
			tnext = (fd * len) / ad;
		end
	endfunction

	function automatic hit_t found(longint x, longint y, longint z,
			longint nx, longint ny, longint nz, longint unsigned t);
		hit_t h;
		h.hit = 1'b1;
		h.tx = x[7:0]; h.ty = y[7:0]; h.tz = z[7:0];
		h.nx = nx[1:0]; h.ny = ny[1:0]; h.nz = nz[1:0];
		h.px = 8'(x + nx); h.py = 8'(y + ny); h.pz = 8'(z + nz);
		h.dst = t[23:0];
		return h;
	endfunction

	// applies a write to the grid copy, or walks a cast; returns the result
	function automatic hit_t trace_ray(req_t r);
		longint d[3], c[3], stp[3], nx, ny, nz, s;
		longint unsigned f[3], tn[3], tg[3], len, lim, rc, t;
		hit_t none = '0;
		if (r.kind == REQ_WRITE) begin
			occ[(int'(r.vx) * GRID + int'(r.vy)) * GRID + int'(r.vz)] = r.sb;
			return none;
		end
		d[0] = r.dx; d[1] = r.dy; d[2] = r.dz;
		if (d[0] == 0 && d[1] == 0 && d[2] == 0) return none;
		len = int_sqrt(longint'(d[0]*d[0] + d[1]*d[1] + d[2]*d[2]) << 16);
		for (int a = 0; a < 3; a++) begin
			s = (a == 0) ? longint'(r.sx) : (a == 1) ? longint'(r.sy) : longint'(r.sz);
			c[a] = s >>> FRAC;
			f[a] = s & ((64'd1 << FRAC) - 1);
			axis_init(d[a], f[a], len, stp[a], tn[a], tg[a]);
		end
		if (solid_at(c[0], c[1], c[2])) return found(c[0], c[1], c[2], 0, 1, 0, 0);
		rc = r.rch;
		lim = longint'(REACH_CAP) << FRAC;
		if (rc > lim) rc = lim;
		lim = rc << 8;
		t = 0;
		while (t <= lim) begin
			// strict compares; ties fall to the later axis
			if (tn[0] < tn[1] && tn[0] < tn[2]) begin
				t = tn[0]; tn[0] += tg[0]; c[0] += stp[0];
				nx = -stp[0]; ny = 0; nz = 0;
			end else if (!(tn[0] < tn[1]) && tn[1] < tn[2]) begin
				t = tn[1]; tn[1] += tg[1]; c[1] += stp[1];
				nx = 0; ny = -stp[1]; nz = 0;
			end else begin
				t = tn[2]; tn[2] += tg[2]; c[2] += stp[2];
				nx = 0; ny = 0; nz = -stp[2];
			end
			if (t > lim) break;
			if (solid_at(c[0], c[1], c[2]))
				return found(c[0], c[1], c[2], nx, ny, nz, t >> 8);
		end
		return none;
	endfunction

	// ---- stimulus helpers -----------------------------------------------

	function automatic req_t mk(logic k, int vx, int vy, int vz, logic sb,
			int sx, int sy, int sz, int dx, int dy, int dz, int rch);
		req_t r;
		r.kind = k;
		r.vx = 5'(vx); r.vy = 5'(vy); r.vz = 5'(vz); r.sb = sb;
		r.sx = 24'(sx); r.sy = 24'(sy); r.sz = 24'(sz);
		r.dx = 16'(dx); r.dy = 16'(dy); r.dz = 16'(dz); r.rch = 24'(rch);
		return r;
	endfunction

	// Q8.16 coordinate from cell and fraction
	function automatic int q(int cl, int fr);
		return cl * 65536 + fr;
	endfunction

	function automatic req_t rand_req();
		req_t r;
		logic [191:0] raw_v;
		raw_v = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
		r = raw_v[$bits(req_t)-1:0];
		if ($urandom_range(99) < 35) begin
			r.kind = REQ_WRITE;
			// cluster most writes in a block that casts aim at
			if ($urandom_range(9) < 8) begin
				r.vx = 5'($urandom_range(6, 18));
				r.vy = 5'($urandom_range(6, 18));
				r.vz = 5'($urandom_range(6, 18));
			end
			r.sb = ($urandom_range(9) < 7);
		end else begin
			r.kind = REQ_CAST;
			if ($urandom_range(9) < 8) begin
				r.sx = 24'(q($urandom_range(0, 24), $urandom_range(0, 65535)));
				r.sy = 24'(q($urandom_range(0, 24), $urandom_range(0, 65535)));
				r.sz = 24'(q($urandom_range(0, 24), $urandom_range(0, 65535)));
				if ($urandom_range(4) == 0) r.sx[15:0] = '0;	// on a boundary
			end
			case ($urandom_range(9))
				0: r.dx = '0;
				1: r.dy = '0;
				2: begin r.dz = '0; r.dy = '0; end
				3: r.dx = r.dy;
				default: ;
			endcase
			if ($urandom_range(49) == 0) begin r.dx = '0; r.dy = '0; r.dz = '0; end
			if ($urandom_range(9) < 8) r.rch = 24'($urandom_range(0, 20 << 16));
		end
		return r;
	endfunction

	// presents one item and waits for its acceptance; queues the expectation
	task automatic offer(req_t r, bit typed, hit_t want);
		hit_t pred;
		@(negedge clk);
		while ($urandom_range(99) < snd_idle) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		drv <= r;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		pred = trace_ray(r);
		pending_hits.push_back(typed ? want : pred);
		if (r.kind == REQ_CAST) begin
			n_casts++;
			if (pred.hit) n_hits++;
		end else begin
			n_writes++;
		end
	endtask

	task automatic field_chk(string nm, longint e, longint a);
		if (e != a) begin
			$display("%0t mismatch %s: expected %0d actual %0d", $time, nm, e, a);
			errors++;
		end
	endtask

	// ---- receiver, checker, watchdog ------------------------------------

	always @(negedge clk) begin
		out_ready <= !hold_off && ($urandom_range(99) >= rcv_idle);
	end

	initial begin
		wait (hold_go);
		hold_off = 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_off = 1'b0;
	end

	always @(posedge clk) begin
		hit_t e;
		if (out_valid && !out_ready) stall_cycles++;
		if (out_valid && out_ready) begin
			if (pending_hits.size() == 0) begin
				$display("%0t unexpected result: hit %0d", $time, got.hit);
				errors++;
			end else begin
				e = pending_hits.pop_front();
				field_chk("hit", e.hit, got.hit);
				field_chk("target_x", e.tx, got.tx);
				field_chk("target_y", e.ty, got.ty);
				field_chk("target_z", e.tz, got.tz);
				field_chk("normal_x", e.nx, got.nx);
				field_chk("normal_y", e.ny, got.ny);
				field_chk("normal_z", e.nz, got.nz);
				field_chk("place_x", e.px, got.px);
				field_chk("place_y", e.py, got.py);
				field_chk("place_z", e.pz, got.pz);
				field_chk("distance", e.dst, got.dst);
			end
		end
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet <= 0;
		end else if (quiet >= WATCHDOG) begin
			$display("%0t watchdog: no handshake for %0d cycles", $time, quiet);
			$display("== FAIL ==");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	// ---- main sequence --------------------------------------------------

	initial begin
		hit_t zero = '0;
		hit_t h;
		foreach (occ[i]) occ[i] = 1'b0;

		// directed table; typed rows have results plain from the spec
		rows[0]  = mk(REQ_WRITE, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0);
		rows[1]  = mk(REQ_WRITE, 31, 31, 31, 1, 0, 0, 0, 0, 0, 0, 0);
		rows[2]  = mk(REQ_WRITE, 10, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0);
		// zero direction inside a solid voxel: miss
		rows[3]  = mk(REQ_CAST, 0, 0, 0, 0, q(0, 32768), q(0, 32768), q(0, 32768),
			0, 0, 0, 24'hFFFFFF);
		// solid start voxel
		rows[4]  = mk(REQ_CAST, 0, 0, 0, 0, q(0, 32768), q(0, 32768), q(0, 32768),
			32767, 0, 0, 24'hFFFFFF);
		rows[5]  = mk(REQ_CAST, 0, 0, 0, 0, q(31, 32768), q(31, 32768), q(31, 32768),
			-32768, -32768, -32768, 0);
		rows[6]  = mk(REQ_CAST, 0, 0, 0, 0, q(-3, 32768), q(0, 32768), q(0, 32768),
			32767, 0, 0, 24'hFFFFFF);
		rows[7]  = mk(REQ_CAST, 0, 0, 0, 0, q(5, 32768), q(0, 32768), q(0, 32768),
			-32768, 0, 0, 24'h0F0000);
		rows[8]  = mk(REQ_CAST, 0, 0, 0, 0, q(5, 32768), q(0, 32768), q(0, 32768),
			32767, 0, 0, 0);
		// exact boundaries, three-way tie
		rows[9]  = mk(REQ_CAST, 0, 0, 0, 0, q(3, 0), q(3, 0), q(3, 0),
			-32768, -32768, -32768, 24'h100000);
		rows[10] = mk(REQ_CAST, 0, 0, 0, 0, q(-3, 0), q(-3, 0), q(-3, 0),
			32767, 32767, 32767, 24'hFFFFFF);
		rows[11] = mk(REQ_CAST, 0, 0, 0, 0, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF,
			-1, -2, -3, 24'hFFFFFF);
		rows[12] = mk(REQ_CAST, 0, 0, 0, 0, 24'h800000, 24'h800000, 24'h800000,
			1, 1, 1, 24'hFFFFFF);
		rows[13] = mk(REQ_CAST, 0, 0, 0, 0, q(9, 32768), q(0, 32768), q(0, 32768),
			32767, 0, 1, 24'h0A0000);
		rows[14] = mk(REQ_WRITE, 21, 10, 21, 0, 0, 0, 0, 0, 0, 0, 0);
		rows[15] = mk(REQ_WRITE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		rows[16] = mk(REQ_CAST, 0, 0, 0, 0, q(0, 32768), q(0, 32768), q(0, 32768),
			1, 0, 0, 24'hFFFFFF);
		// start outside the grid, walk back in
		rows[17] = mk(REQ_CAST, 0, 0, 0, 0, q(40, 0), q(0, 32768), q(0, 32768),
			-1, 0, 0, 24'hFFFFFF);
		rows[18] = mk(REQ_CAST, 0, 0, 0, 0, q(0, 32768), q(0, 32768), q(0, 32768),
			0, 0, 0, 0);

		foreach (typed_row[i]) begin
			typed_row[i] = 1'b0;
			typed_hit[i] = zero;
		end
		foreach (rows[i])
			if (rows[i].kind == REQ_WRITE) typed_row[i] = 1'b1;
		typed_row[3] = 1'b1;
		typed_row[18] = 1'b1;
		typed_row[4] = 1'b1;
		h = zero; h.hit = 1'b1; h.ny = 2'sd1; h.py = 8'sd1;
		typed_hit[4] = h;
		typed_row[5] = 1'b1;
		h = zero; h.hit = 1'b1; h.tx = 8'sd31; h.ty = 8'sd31; h.tz = 8'sd31;
		h.ny = 2'sd1; h.px = 8'sd31; h.py = 8'sd32; h.pz = 8'sd31;
		typed_hit[5] = h;

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int i = 0; i < N_ROWS; i++) offer(rows[i], typed_row[i], typed_hit[i]);

		// three idle mixes; the long receiver hold-off lands in the first
		for (int ph = 0; ph < 3; ph++) begin
			snd_idle = (ph == 0) ? 37 : (ph == 1) ? 45 : 0;
			rcv_idle = (ph == 0) ? 45 : (ph == 1) ? 37 : 0;
			if (ph == 0) hold_go = 1'b1;
			for (int n = 0; n < N_RANDOM / 3; n++) offer(rand_req(), 1'b0, zero);
		end

		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_hits.size() != 0) @(posedge clk);
		repeat (400) @(posedge clk);

		$display("covered %0d writes and %0d casts (%0d predicted hits), %0d output stalls",
			n_writes, n_casts, n_hits, stall_cycles);
		if (errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("%0d mismatches", errors);
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
